/* rtl/core/mne_pkg.sv */
package mne_pkg;

  localparam int VERTEX_SLOTS = 4096;
  localparam int EDGE_SLOTS   = 16384;
  localparam int MAX_RESULTS  = 64;
  localparam int STAMP_DEPTH  = 4096;

  localparam int VA_W   = $clog2(VERTEX_SLOTS);
  localparam int EA_W   = $clog2(EDGE_SLOTS);
  localparam int SA_W   = $clog2(STAMP_DEPTH);
  localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

  localparam int VW_W   = 15;  // vertex-index word
  localparam int NODE_W = 12;  // node / edge word
  localparam int SER_W  = 16;
  localparam int BND_W  = 21;
  localparam int PROD_W = 22;

  localparam logic [PROD_W-1:0] BOUND_MAX = PROD_W'(1048575);

  localparam logic [1:0] CMD_WR_VTX  = 2'd0;
  localparam logic [1:0] CMD_WR_EDGE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic REG_NODE_BASE  = 1'b0;
  localparam logic REG_MAX_DEGREE = 1'b1;

endpackage

/* rtl/core/mne_ram.sv */
module mne_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mesh_node_neighbor_enumerator.sv */
// Neighbor enumerator over a node-element mesh held in three single-port-read
// RAMs (vertex index, edge list, per-node visit stamp). Store writes are taken
// while idle and can follow back to back. A query walks its node's elements
// and their members one at a time through the shared RAM read ports, and it
// can stall on the result port. Input is held off while a query runs. After
// reset, and whenever the 16-bit query serial wraps, a stamp clear sweep over
// all 4096 stamp entries runs before the next item is taken; config writes
// are always taken. Results of a query leave in order, the last one flagged.
module mesh_node_neighbor_enumerator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [mne_pkg::NODE_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            cmd,
  input  logic [13:0]                           slot,
  input  logic [mne_pkg::VW_W-1:0]              word,
  input  logic [mne_pkg::NODE_W-1:0]            node,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mne_pkg::NODE_W-1:0]            neighbor,
  output logic                                  none,
  output logic                                  last,
  output logic                                  truncated,
  output logic signed [mne_pkg::BND_W-1:0]      degree_bound
);
  import mne_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_CLR = 4'd1,  S_RS  = 4'd2,  S_RE  = 4'd3,
                         S_CNT  = 4'd4,  S_BND = 4'd5,  S_EL  = 4'd6,  S_EW  = 4'd7,
                         S_MS   = 4'd8,  S_ME  = 4'd9,  S_MEM = 4'd10, S_MW  = 4'd11,
                         S_CHK  = 4'd12, S_PUSH = 4'd13, S_FIN = 4'd14;

  logic [3:0]              state;
  logic [SA_W-1:0]         clr_cnt;
  logic [SER_W-1:0]        serial;
  logic [NODE_W-1:0]       node_base;
  logic [6:0]              max_degree;
  logic [NODE_W:0]         self;
  logic [VW_W-1:0]         es, ee, e, ms, me, m, cnt;
  logic [NODE_W-1:0]       elm, mem_r, pend_nb;
  logic                    pend_valid, more;
  logic [RCNT_W-1:0]       n;
  logic signed [BND_W-1:0] bound;
  logic                    vtx_oob, edge_oob;

  // RAM ports
  logic                    vtx_we, edge_we, stp_we;
  logic [VA_W-1:0]         vtx_wa;
  logic [EA_W-1:0]         edge_wa;
  logic [SA_W-1:0]         stp_wa, stp_ra;
  logic [SER_W-1:0]        stp_wd, stp_rd;
  logic [VW_W-1:0]         vtx_rd;
  logic [NODE_W-1:0]       edge_rd;
  logic [31:0]             vra_full, era_full;
  logic [VW_W-1:0]         vtx_val;
  logic [NODE_W-1:0]       edge_val;
  logic [31:0]             slot_full;
  logic                    in_acc, out_free, out_load;
  logic [PROD_W-1:0]       prod;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == S_PUSH && pend_valid) || state == S_FIN);
  assign slot_full = 32'(slot);
  assign vtx_val   = vtx_oob ? '0 : vtx_rd;
  assign edge_val  = edge_oob ? '0 : edge_rd;
  assign prod      = PROD_W'(max_degree) * PROD_W'(cnt);

  assign vtx_we  = in_acc && (cmd == CMD_WR_VTX) && (slot_full < VERTEX_SLOTS);
  assign vtx_wa  = slot_full[VA_W-1:0];
  assign edge_we = in_acc && (cmd == CMD_WR_EDGE) && (slot_full < EDGE_SLOTS);
  assign edge_wa = slot_full[EA_W-1:0];

  always_comb begin
    vra_full = 32'(self);
    era_full = 32'(e);
    stp_we   = 1'b0;
    stp_wa   = mem_r;
    stp_wd   = serial;
    stp_ra   = edge_val;
    unique case (state)
      S_RE:  begin
        vra_full = 32'(self) + 32'd1;
        stp_we   = !self[NODE_W];
        stp_wa   = self[SA_W-1:0];
      end
      S_EW:  vra_full = 32'(edge_val);
      S_MS:  vra_full = 32'(elm) + 32'd1;
      S_MEM: era_full = 32'(m);
      S_CHK: stp_we = (stp_rd != serial) && (n != RCNT_W'(MAX_RESULTS));
      S_CLR: begin
        stp_we = 1'b1;
        stp_wa = clr_cnt;
        stp_wd = '0;
      end
      default: ;
    endcase
  end

  mne_ram #(.WIDTH(VW_W), .DEPTH(VERTEX_SLOTS)) u_vtx (
    .clk(clk), .we(vtx_we), .waddr(vtx_wa), .wdata(word),
    .raddr(vra_full[VA_W-1:0]), .rdata(vtx_rd)
  );
  mne_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_SLOTS)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(word[NODE_W-1:0]),
    .raddr(era_full[EA_W-1:0]), .rdata(edge_rd)
  );
  mne_ram #(.WIDTH(SER_W), .DEPTH(STAMP_DEPTH)) u_stamp (
    .clk(clk), .we(stp_we), .waddr(stp_wa), .wdata(stp_wd),
    .raddr(stp_ra), .rdata(stp_rd)
  );

  always_ff @(posedge clk) begin
    vtx_oob  <= (vra_full >= VERTEX_SLOTS);
    edge_oob <= (era_full >= EDGE_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_base  <= '0;
      max_degree <= 7'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NODE_BASE:  node_base  <= cfg_data;
        REG_MAX_DEGREE: max_degree <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      serial     <= SER_W'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      more       <= 1'b0;
      n          <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && cmd == CMD_QUERY) begin
            self  <= {1'b0, node} + {1'b0, node_base};
            n     <= '0;
            more  <= 1'b0;
            state <= S_RS;
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SA_W'(STAMP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_RS: state <= S_RE;
        S_RE: begin
          es    <= vtx_val;
          state <= S_CNT;
        end
        S_CNT: begin
          ee    <= vtx_val;
          cnt   <= (vtx_val > es) ? vtx_val - es : '0;
          e     <= es;
          state <= S_BND;
        end
        S_BND: begin
          if (prod == '0) begin
            bound <= -BND_W'(1);
          end else if (prod > BOUND_MAX + 1'b1) begin
            bound <= BND_W'(BOUND_MAX);
          end else begin
            bound <= BND_W'(prod - 1'b1);
          end
          state <= S_EL;
        end
        S_EL: state <= (e < ee) ? S_EW : S_FIN;
        S_EW: begin
          elm   <= edge_val;
          state <= S_MS;
        end
        S_MS: begin
          ms    <= vtx_val;
          state <= S_ME;
        end
        S_ME: begin
          me    <= vtx_val;
          m     <= ms;
          state <= S_MEM;
        end
        S_MEM: begin
          if (m < me) begin
            state <= S_MW;
          end else begin
            e     <= e + 1'b1;
            state <= S_EL;
          end
        end
        S_MW: begin
          mem_r <= edge_val;
          state <= S_CHK;
        end
        S_CHK: begin
          if (stp_rd == serial) begin
            m     <= m + 1'b1;
            state <= S_MEM;
          end else if (n == RCNT_W'(MAX_RESULTS)) begin
            more  <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold one neighbor back so the final one can carry last
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid    <= 1'b1;
              neighbor     <= pend_nb;
              none         <= 1'b0;
              last         <= 1'b0;
              truncated    <= 1'b0;
              degree_bound <= bound;
            end
            pend_nb    <= mem_r - node_base;
            pend_valid <= 1'b1;
            n          <= n + 1'b1;
            m          <= m + 1'b1;
            state      <= S_MEM;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            neighbor     <= pend_valid ? pend_nb : '0;
            none         <= !pend_valid;
            last         <= 1'b1;
            truncated    <= pend_valid && more;
            degree_bound <= bound;
            pend_valid   <= 1'b0;
            if (serial == '1) begin
              serial  <= SER_W'(1);
              clr_cnt <= '0;
              state   <= S_CLR;
            end else begin
              serial <= serial + 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid) else $error("neighbor held back while idle");
  a_serial_nonzero: assert property (@(posedge clk) disable iff (rst)
    serial != '0) else $error("query serial reached zero");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    n <= RCNT_W'(MAX_RESULTS)) else $error("result count past limit");
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && last))
    else $error("query end without last result");

endmodule
